@@ src/smre_pkg.sv @@
// Shared types, constants and width helpers for the matrix record encoder.
`timescale 1ns / 1ps
`default_nettype none
package smre_pkg;

   localparam int WIDTH_FIELD_BITS = 5;
   localparam int IN_BITS          = 31;
   localparam int MAX_BYTES        = 26;
   localparam int REC_BITS         = MAX_BYTES * 8;
   localparam int SEG_BITS         = 32;
   localparam int NUM_STEPS        = 9;

   // Segment order within one record.
   localparam logic [3:0] SEG_SCALE_HDR = 4'd0;
   localparam logic [3:0] SEG_SCALE_X   = 4'd1;
   localparam logic [3:0] SEG_SCALE_Y   = 4'd2;
   localparam logic [3:0] SEG_SKEW_HDR  = 4'd3;
   localparam logic [3:0] SEG_SKEW_0    = 4'd4;
   localparam logic [3:0] SEG_SKEW_1    = 4'd5;
   localparam logic [3:0] SEG_MOVE_HDR  = 4'd6;
   localparam logic [3:0] SEG_MOVE_X    = 4'd7;
   localparam logic [3:0] SEG_MOVE_Y    = 4'd8;

   typedef struct packed {
      logic [IN_BITS-1:0]          scale_x;
      logic [IN_BITS-1:0]          skew_first;
      logic [IN_BITS-1:0]          skew_second;
      logic [IN_BITS-1:0]          scale_y;
      logic [IN_BITS-1:0]          move_x;
      logic [IN_BITS-1:0]          move_y;
      logic                        scale_on;
      logic                        skew_on;
      logic [WIDTH_FIELD_BITS-1:0] scale_w;
      logic [WIDTH_FIELD_BITS-1:0] skew_w;
      logic [WIDTH_FIELD_BITS-1:0] move_w;
   } item_type;

   function automatic logic [IN_BITS-1:0] magnitude(input logic [IN_BITS-1:0] v);
      logic [IN_BITS-1:0] neg;
      neg = ~v + 1'b1;
      return v[IN_BITS-1] ? neg : v;
   endfunction

   // 2 + floor(log2) of the larger magnitude; OR of both has the same top bit.
   function automatic logic [WIDTH_FIELD_BITS-1:0] pair_width(
      input logic [IN_BITS-1:0] p,
      input logic [IN_BITS-1:0] q
   );
      logic [IN_BITS-1:0] m;
      logic [5:0]         w;
      m = magnitude(p) | magnitude(q);
      w = 6'd2;
      for (int i = 1; i < IN_BITS; i++) begin
         if (m[i]) begin
            w = 6'(i + 2);
         end
      end
      if (w > 6'(IN_BITS)) begin
         w = 6'(IN_BITS);
      end
      return w[WIDTH_FIELD_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

@@ src/swf_matrix_record_encoder.sv @@
// Top level of the matrix record encoder: front, queue and back end.
// An accepted request passes the front register, the queue write, the packer load,
//   nine packing steps and the handoff (once the back end is free) to the result ports.
// Records are N bytes (2 to 26); the packer loads and packs the next record in its
//   nine-step segment loop while the current one is still draining.
// Reset (synchronous, active high) empties the queue and drops any record in flight.
`timescale 1ns / 1ps
`default_nettype none
module swf_matrix_record_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic signed [30:0]  req_scale_x,
   input  wire logic signed [30:0]  req_skew_first,
   input  wire logic signed [30:0]  req_skew_second,
   input  wire logic signed [30:0]  req_scale_y,
   input  wire logic signed [30:0]  req_move_x,
   input  wire logic signed [30:0]  req_move_y,
   input  wire logic                rsp_pop,
   output logic                     rsp_empty,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last
);
   import smre_pkg::*;

   // Classified item crossing from front to queue, and queue head to back.
   item_type front_item;
   item_type head_item;
   logic     front_push;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;

   // Front: hold one transfer and work out the three field widths.
   smre_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_scale_x     (req_scale_x),
      .req_skew_first  (req_skew_first),
      .req_skew_second (req_skew_second),
      .req_scale_y     (req_scale_y),
      .req_move_x      (req_move_x),
      .req_move_y      (req_move_y),
      .q_full          (q_full),
      .q_push          (front_push),
      .q_item          (front_item)
   );

   // Decouple classification from packing so each side stalls on its own.
   smre_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (head_item),
      .empty     (q_empty)
   );

   // Back: pack segments MSB first, then stream the record one byte per transfer.
   // The next record is packed while the current one is still draining.
   smre_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_item       (head_item),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
`default_nettype wire

@@ src/smre_front.sv @@
// Front end: input register and per-pair width classification.
`timescale 1ns / 1ps
`default_nettype none
module smre_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic signed [30:0]            req_scale_x,
   input  wire logic signed [30:0]            req_skew_first,
   input  wire logic signed [30:0]            req_skew_second,
   input  wire logic signed [30:0]            req_scale_y,
   input  wire logic signed [30:0]            req_move_x,
   input  wire logic signed [30:0]            req_move_y,
   input  wire logic                          q_full,
   output logic                               q_push,
   output smre_pkg::item_type                 q_item
);
   import smre_pkg::*;

   logic     valid_ff, valid_in;
   item_type raw_ff, raw_in;
   logic     accept;

   // Stall only when the held item cannot drain into the queue.
   assign req_full = valid_ff & q_full;
   assign accept   = req_push & ~req_full;
   assign q_push   = valid_ff & ~q_full;

   always_comb begin
      raw_in             = raw_ff;
      raw_in.scale_x     = req_scale_x;
      raw_in.skew_first  = req_skew_first;
      raw_in.skew_second = req_skew_second;
      raw_in.scale_y     = req_scale_y;
      raw_in.move_x      = req_move_x;
      raw_in.move_y      = req_move_y;
      valid_in           = accept | (valid_ff & ~q_push);
   end

   always_comb begin
      q_item          = raw_ff;
      q_item.scale_on = |(raw_ff.scale_x | raw_ff.scale_y);
      q_item.skew_on  = |(raw_ff.skew_first | raw_ff.skew_second);
      q_item.scale_w  = pair_width(raw_ff.scale_x, raw_ff.scale_y);
      q_item.skew_w   = pair_width(raw_ff.skew_first, raw_ff.skew_second);
      q_item.move_w   = pair_width(raw_ff.move_x, raw_ff.move_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         raw_ff <= raw_in;
      end
   end

endmodule
`default_nettype wire

@@ src/smre_queue.sv @@
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none
module smre_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire smre_pkg::item_type  push_item,
   output logic                     full,
   input  wire logic                pop,
   output smre_pkg::item_type       head_item,
   output logic                     empty
);
   import smre_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   item_type              slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

@@ src/smre_back.sv @@
// Back end: segment packer into a record buffer and byte emitter.
`timescale 1ns / 1ps
`default_nettype none
module smre_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire smre_pkg::item_type  q_item,
   input  wire logic                q_empty,
   output logic                     q_pop,
   input  wire logic                rsp_pop,
   output logic                     rsp_empty,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last
);
   import smre_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PACK,
      ST_HOLD
   } state_type;

   localparam int POS_BITS  = $clog2(REC_BITS + 1);
   localparam int LEN_BITS  = $clog2(SEG_BITS + 1);
   localparam int BYTE_BITS = $clog2(MAX_BYTES + 1);

   state_type            state_ff, state_in;
   item_type             item_ff, item_in;
   logic [3:0]           step_ff, step_in;
   logic [REC_BITS-1:0]  acc_ff, acc_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [REC_BITS-1:0]  sh_ff, sh_in;
   logic [BYTE_BITS-1:0] left_ff, left_in;

   logic [SEG_BITS-1:0]  seg_val;
   logic [LEN_BITS-1:0]  seg_len;
   logic [SEG_BITS-1:0]  seg_aligned;
   logic [REC_BITS-1:0]  seg_wide;
   logic [POS_BITS:0]    pos_round;
   logic [BYTE_BITS-1:0] rec_bytes;
   logic                 handoff;

   // Pick the current segment: value right-aligned, length in bits.
   always_comb begin
      seg_val = '0;
      seg_len = '0;
      case (step_ff)
         SEG_SCALE_HDR: begin
            seg_val = item_ff.scale_on ? SEG_BITS'({1'b1, item_ff.scale_w}) : '0;
            seg_len = item_ff.scale_on ? LEN_BITS'(WIDTH_FIELD_BITS + 1) : LEN_BITS'(1);
         end
         SEG_SCALE_X: begin
            seg_val = SEG_BITS'(item_ff.scale_x);
            seg_len = item_ff.scale_on ? LEN_BITS'(item_ff.scale_w) : '0;
         end
         SEG_SCALE_Y: begin
            seg_val = SEG_BITS'(item_ff.scale_y);
            seg_len = item_ff.scale_on ? LEN_BITS'(item_ff.scale_w) : '0;
         end
         SEG_SKEW_HDR: begin
            seg_val = item_ff.skew_on ? SEG_BITS'({1'b1, item_ff.skew_w}) : '0;
            seg_len = item_ff.skew_on ? LEN_BITS'(WIDTH_FIELD_BITS + 1) : LEN_BITS'(1);
         end
         SEG_SKEW_0: begin
            seg_val = SEG_BITS'(item_ff.skew_first);
            seg_len = item_ff.skew_on ? LEN_BITS'(item_ff.skew_w) : '0;
         end
         SEG_SKEW_1: begin
            seg_val = SEG_BITS'(item_ff.skew_second);
            seg_len = item_ff.skew_on ? LEN_BITS'(item_ff.skew_w) : '0;
         end
         SEG_MOVE_HDR: begin
            seg_val = SEG_BITS'(item_ff.move_w);
            seg_len = LEN_BITS'(WIDTH_FIELD_BITS);
         end
         SEG_MOVE_X: begin
            seg_val = SEG_BITS'(item_ff.move_x);
            seg_len = LEN_BITS'(item_ff.move_w);
         end
         SEG_MOVE_Y: begin
            seg_val = SEG_BITS'(item_ff.move_y);
            seg_len = LEN_BITS'(item_ff.move_w);
         end
         default: begin
            seg_val = '0;
            seg_len = '0;
         end
      endcase
   end

   // Left-align the segment (drops bits above its length), then place it at pos.
   assign seg_aligned = seg_val << (LEN_BITS'(SEG_BITS) - seg_len);
   assign seg_wide    = {seg_aligned, {(REC_BITS - SEG_BITS){1'b0}}} >> pos_ff;
   assign pos_round   = {1'b0, pos_ff} + (POS_BITS + 1)'(7);
   assign rec_bytes   = BYTE_BITS'(pos_round >> 3);

   assign rsp_empty    = (left_ff == '0);
   assign rsp_out_byte = sh_ff[REC_BITS-1 -: 8];
   assign rsp_last     = (left_ff == BYTE_BITS'(1));
   assign q_pop        = (state_ff == ST_IDLE) & ~q_empty;
   assign handoff      = (state_ff == ST_HOLD) & (rsp_empty | (rsp_last & rsp_pop));

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      step_in  = step_ff;
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      sh_in    = sh_ff;
      left_in  = left_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               item_in  = q_item;
               step_in  = '0;
               acc_in   = '0;
               pos_in   = '0;
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            acc_in  = acc_ff | seg_wide;
            pos_in  = pos_ff + POS_BITS'(seg_len);
            step_in = step_ff + 1'b1;
            if (step_ff == 4'(NUM_STEPS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (handoff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Emitter: reload on handoff, otherwise advance one byte per transfer.
      if (handoff) begin
         sh_in   = acc_ff;
         left_in = rec_bytes;
      end else if (rsp_pop & ~rsp_empty) begin
         sh_in   = sh_ff << 8;
         left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
      end
      item_ff <= item_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      pos_ff  <= pos_in;
      sh_ff   <= sh_in;
   end

endmodule
`default_nettype wire
